// ===== sv/assert_macros.svh =====
// assertion macros shared by the colormap rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, held off during reset
`define ASSERT_NOW(label, ck, rs, ante, cons) \
  label: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle check");

// next-cycle implication, held off during reset
`define ASSERT_NEXT(label, ck, rs, ante, cons) \
  label: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle check");

`endif

// ===== sv/cmap_pkg.sv =====
// types and constants of the scalar colormap block
package cmap_pkg;

  localparam int T_BITS = 16;

  localparam logic [T_BITS:0] T_ONE  = 17'h10000;
  localparam logic [T_BITS:0] T_HALF = 17'h08000;

  localparam logic [7:0] GRAY_LEVEL = 8'd128;
  localparam logic [7:0] CHAN_MAX   = 8'd255;

  localparam logic MODE_RAINBOW = 1'b0;
  localparam logic MODE_DIVERGE = 1'b1;

  localparam logic [1:0] REG_RANGE_LOW  = 2'd0;
  localparam logic [1:0] REG_RANGE_HIGH = 2'd1;
  localparam logic [1:0] REG_RAMP_MODE  = 2'd2;

  // control carried alongside each item through the chain
  typedef struct packed {
    logic            live;
    logic            gray;
    logic            fixed;
    logic [T_BITS:0] t_fixed;
  } ctl_t;

endpackage

// ===== sv/cmap_if.sv =====
// handshake channels for samples and colors
interface cmap_sample_if #(parameter int SCALAR_BITS = 32);
  logic                          valid;
  logic                          ready;
  logic signed [SCALAR_BITS-1:0] sample_value;
  logic                          sample_valid;

  modport source(output valid, sample_value, sample_valid, input ready);
  modport sink(input valid, sample_value, sample_valid, output ready);
endinterface

interface cmap_color_if;
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;

  modport source(output valid, red, green, blue, input ready);
  modport sink(input valid, red, green, blue, output ready);
endinterface

// ===== sv/cmap_front.sv =====
// range differences and classification ahead of the divider chain
module cmap_front #(
  parameter int SCALAR_BITS = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  logic                          in_live,
  input  logic signed [SCALAR_BITS-1:0] in_value,
  input  logic                          in_flag,
  input  logic signed [SCALAR_BITS-1:0] range_low,
  input  logic signed [SCALAR_BITS-1:0] range_high,
  output cmap_pkg::ctl_t                ctl_out,
  output logic [SCALAR_BITS-1:0]        rem_out,
  output logic [SCALAR_BITS-1:0]        den_out
);

  localparam int DW = SCALAR_BITS + 1;

  // stage one: all four differences in parallel
  logic             live1;
  logic             gray1;
  logic signed [DW-1:0] num_pos, num_neg, den_pos, den_neg;

  always_ff @(posedge clk) begin
    if (rst) begin
      live1 <= 1'b0;
    end else if (en) begin
      live1 <= in_live;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      gray1   <= !in_flag;
      num_pos <= DW'(in_value) - DW'(range_low);
      num_neg <= DW'(range_low) - DW'(in_value);
      den_pos <= DW'(range_high) - DW'(range_low);
      den_neg <= DW'(range_low) - DW'(range_high);
    end
  end

  // stage two: orient by the sign of the span and classify
  logic signed [DW-1:0] n, d;
  logic                 den_zero;
  cmap_pkg::ctl_t       ctl_next;

  always_comb begin
    den_zero = (den_pos == '0);
    n = den_pos[DW-1] ? num_neg : num_pos;
    d = den_pos[DW-1] ? den_neg : den_pos;
    ctl_next.live    = live1;
    ctl_next.gray    = gray1;
    ctl_next.fixed   = 1'b1;
    ctl_next.t_fixed = cmap_pkg::T_HALF;
    if (den_zero) begin
      ctl_next.t_fixed = cmap_pkg::T_HALF;
    end else if (n[DW-1] || n == '0) begin
      ctl_next.t_fixed = '0;
    end else if (n >= d) begin
      ctl_next.t_fixed = cmap_pkg::T_ONE;
    end else begin
      ctl_next.fixed = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_out.live <= 1'b0;
    end else if (en) begin
      ctl_out.live <= ctl_next.live;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctl_out.gray    <= ctl_next.gray;
      ctl_out.fixed   <= ctl_next.fixed;
      ctl_out.t_fixed <= ctl_next.t_fixed;
      rem_out         <= n[SCALAR_BITS-1:0];
      den_out         <= d[SCALAR_BITS-1:0];
    end
  end

endmodule

// ===== sv/cmap_div_cell.sv =====
// one restoring-division cell: produces one quotient bit of t
`include "assert_macros.svh"

module cmap_div_cell #(
  parameter int SCALAR_BITS = 32
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              en,
  input  cmap_pkg::ctl_t                    ctl_in,
  input  logic [SCALAR_BITS-1:0]            rem_in,
  input  logic [SCALAR_BITS-1:0]            den_in,
  input  logic [cmap_pkg::T_BITS-1:0]       q_in,
  output cmap_pkg::ctl_t                    ctl_out,
  output logic [SCALAR_BITS-1:0]            rem_out,
  output logic [SCALAR_BITS-1:0]            den_out,
  output logic [cmap_pkg::T_BITS-1:0]       q_out
);

  logic [SCALAR_BITS:0]   shifted;
  logic [SCALAR_BITS:0]   diff;
  logic                   ge;
  logic [SCALAR_BITS-1:0] rem_next;

  always_comb begin
    shifted  = {rem_in, 1'b0};
    diff     = shifted - {1'b0, den_in};
    ge       = (shifted >= {1'b0, den_in});
    rem_next = ge ? diff[SCALAR_BITS-1:0] : shifted[SCALAR_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_out.live <= 1'b0;
    end else if (en) begin
      ctl_out.live <= ctl_in.live;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctl_out.gray    <= ctl_in.gray;
      ctl_out.fixed   <= ctl_in.fixed;
      ctl_out.t_fixed <= ctl_in.t_fixed;
      rem_out         <= rem_next;
      den_out         <= den_in;
      q_out           <= {q_in[cmap_pkg::T_BITS-2:0], ge};
    end
  end

  // a divided item always keeps its partial remainder below the divisor
  `ASSERT_NOW(a_rem_below_den, clk, rst, ctl_out.live && !ctl_out.fixed, rem_out < den_out)

endmodule

// ===== sv/cmap_shade.sv =====
// ramp lookup: turns t into an rgb color, registered at the output
`include "assert_macros.svh"

module cmap_shade (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        en,
  input  cmap_pkg::ctl_t              ctl_in,
  input  logic [cmap_pkg::T_BITS-1:0] q_in,
  input  logic                        ramp_mode,
  output logic                        valid,
  output logic [7:0]                  red,
  output logic [7:0]                  green,
  output logic [7:0]                  blue
);

  localparam logic [2:0] SECTOR_RED_YEL  = 3'd0;
  localparam logic [2:0] SECTOR_YEL_GRN  = 3'd1;
  localparam logic [2:0] SECTOR_GRN_CYAN = 3'd2;
  localparam logic [2:0] SECTOR_CYAN_BLU = 3'd3;

  logic [16:0] t;
  logic [16:0] u;
  logic [18:0] x;
  logic [2:0]  sector;
  logic [15:0] f;
  logic [16:0] f_rest;
  logic [23:0] up_prod, down_prod, lo_prod, hi_prod;
  logic [7:0]  up, down;
  logic [16:0] t_over;
  logic [16:0] fd;
  logic [7:0]  r_next, g_next, b_next;
  logic        gray_q;

  always_comb begin
    t      = ctl_in.fixed ? ctl_in.t_fixed : {1'b0, q_in};
    // rainbow: hue runs from blue at t=0 to red at t=1
    u      = cmap_pkg::T_ONE - t;
    x      = {u, 2'b00};
    sector = x[18:16];
    f      = x[15:0];
    f_rest = cmap_pkg::T_ONE - {1'b0, f};
    up_prod   = 24'(f) * 24'd255 + 24'd32768;
    down_prod = 24'(f_rest) * 24'd255 + 24'd32768;
    up     = up_prod[23:16];
    down   = down_prod[23:16];
    // diverging halves
    lo_prod = 24'(t[14:0]) * 24'd510;
    t_over  = t - cmap_pkg::T_HALF;
    fd      = {t_over[15:0], 1'b0};
    hi_prod = 24'(fd) * 24'd255 + 24'd65535;

    r_next = cmap_pkg::GRAY_LEVEL;
    g_next = cmap_pkg::GRAY_LEVEL;
    b_next = cmap_pkg::GRAY_LEVEL;
    if (!ctl_in.gray) begin
      if (ramp_mode == cmap_pkg::MODE_RAINBOW) begin
        case (sector)
          SECTOR_RED_YEL: begin
            r_next = cmap_pkg::CHAN_MAX; g_next = up; b_next = 8'd0;
          end
          SECTOR_YEL_GRN: begin
            r_next = down; g_next = cmap_pkg::CHAN_MAX; b_next = 8'd0;
          end
          SECTOR_GRN_CYAN: begin
            r_next = 8'd0; g_next = cmap_pkg::CHAN_MAX; b_next = up;
          end
          SECTOR_CYAN_BLU: begin
            r_next = 8'd0; g_next = down; b_next = cmap_pkg::CHAN_MAX;
          end
          default: begin
            r_next = up; g_next = 8'd0; b_next = cmap_pkg::CHAN_MAX;
          end
        endcase
      end else if (t < cmap_pkg::T_HALF) begin
        r_next = lo_prod[23:16];
        g_next = lo_prod[23:16];
        b_next = cmap_pkg::CHAN_MAX;
      end else begin
        r_next = cmap_pkg::CHAN_MAX;
        g_next = cmap_pkg::CHAN_MAX - hi_prod[23:16];
        b_next = cmap_pkg::CHAN_MAX - hi_prod[23:16];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (en) begin
      valid <= ctl_in.live;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      red    <= r_next;
      green  <= g_next;
      blue   <= b_next;
      gray_q <= ctl_in.gray;
    end
  end

  // every ramp color has at least one channel at full scale
  `ASSERT_NOW(a_full_channel, clk, rst, valid && !gray_q, red == cmap_pkg::CHAN_MAX || green == cmap_pkg::CHAN_MAX || blue == cmap_pkg::CHAN_MAX)

endmodule

// ===== sv/scalar_to_colormap_rgb.sv =====
// top level of the scalar to rgb false-color mapper
// Maps one signed fixed-point scalar per item to an 8-bit rgb color. The
// sample is normalized against range_low and range_high into a 16-bit
// fraction t (clamped to 0..1, 0.5 when the two are equal) and colored by
// an hsv rainbow (ramp_mode 0, blue to red) or a blue-white-red diverging
// ramp (ramp_mode 1); items flagged invalid come out as mid gray. A new item
// is taken every cycle in which sample.ready is high. Each item passes a
// front end that forms and then classifies the range differences, sixteen
// cells of a restoring divider that each settle one bit of t and pass the
// partial remainder to the next cell, and a ramp lookup that lands in the
// output register. A one-entry skid buffer at the input keeps sample.ready
// a register, so a stall at the color side reaches the sample side in the
// following cycle. Registers are written through cfg_we/cfg_index/cfg_data
// and should only change while no item is in flight.
`include "assert_macros.svh"

module scalar_to_colormap_rgb #(
  parameter int SCALAR_BITS   = 32,
  parameter int FRACTION_BITS = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [1:0]             cfg_index,
  input  logic [SCALAR_BITS-1:0] cfg_data,
  cmap_sample_if.sink            sample,
  cmap_color_if.source           color
);

  localparam int CELLS = cmap_pkg::T_BITS;

  // configuration registers
  logic signed [SCALAR_BITS-1:0] range_low;
  logic signed [SCALAR_BITS-1:0] range_high;
  logic                          ramp_mode;

  always_ff @(posedge clk) begin
    if (rst) begin
      range_low  <= '0;
      range_high <= SCALAR_BITS'(1) << FRACTION_BITS;
      ramp_mode  <= cmap_pkg::MODE_RAINBOW;
    end else if (cfg_we) begin
      case (cfg_index)
        cmap_pkg::REG_RANGE_LOW:  range_low  <= cfg_data;
        cmap_pkg::REG_RANGE_HIGH: range_high <= cfg_data;
        cmap_pkg::REG_RAMP_MODE:  ramp_mode  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // whole pipe moves when the output register is free or being drained
  logic adv;
  assign adv = !color.valid || color.ready;

  // input skid buffer
  logic                          skid_full;
  logic signed [SCALAR_BITS-1:0] skid_value;
  logic                          skid_flag;

  assign sample.ready = !skid_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      skid_full <= 1'b0;
    end else if (adv) begin
      skid_full <= 1'b0;
    end else if (sample.valid && !skid_full) begin
      skid_full <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!adv && sample.valid && !skid_full) begin
      skid_value <= sample.sample_value;
      skid_flag  <= sample.sample_valid;
    end
  end

  // item entering the pipe: held item first, else straight from the port
  logic                          src_live;
  logic signed [SCALAR_BITS-1:0] src_value;
  logic                          src_flag;

  always_comb begin
    src_live  = skid_full || sample.valid;
    src_value = skid_full ? skid_value : sample.sample_value;
    src_flag  = skid_full ? skid_flag : sample.sample_valid;
  end

  // chain wiring: index 0 is the front end, index CELLS the last cell
  cmap_pkg::ctl_t              ctl_w [CELLS+1];
  logic [SCALAR_BITS-1:0]      rem_w [CELLS+1];
  logic [SCALAR_BITS-1:0]      den_w [CELLS+1];
  logic [cmap_pkg::T_BITS-1:0] q_w   [CELLS+1];

  cmap_front #(.SCALAR_BITS(SCALAR_BITS)) u_front (
    .clk        (clk),
    .rst        (rst),
    .en         (adv),
    .in_live    (src_live),
    .in_value   (src_value),
    .in_flag    (src_flag),
    .range_low  (range_low),
    .range_high (range_high),
    .ctl_out    (ctl_w[0]),
    .rem_out    (rem_w[0]),
    .den_out    (den_w[0])
  );

  // quotient bits shift in from the right, so the start value is unused
  assign q_w[0] = '0;

  for (genvar i = 0; i < CELLS; i++) begin : g_cell
    cmap_div_cell #(.SCALAR_BITS(SCALAR_BITS)) u_cell (
      .clk     (clk),
      .rst     (rst),
      .en      (adv),
      .ctl_in  (ctl_w[i]),
      .rem_in  (rem_w[i]),
      .den_in  (den_w[i]),
      .q_in    (q_w[i]),
      .ctl_out (ctl_w[i+1]),
      .rem_out (rem_w[i+1]),
      .den_out (den_w[i+1]),
      .q_out   (q_w[i+1])
    );
  end

  // final remainder and divisor are not needed past the last cell
  logic unused_tail;
  assign unused_tail = ^{rem_w[CELLS], den_w[CELLS]};

  cmap_shade u_shade (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .ctl_in    (ctl_w[CELLS]),
    .q_in      (q_w[CELLS]),
    .ramp_mode (ramp_mode ^ (unused_tail & 1'b0)),
    .valid     (color.valid),
    .red       (color.red),
    .green     (color.green),
    .blue      (color.blue)
  );

  // an item taken while the pipe is stalled must land in the skid buffer
  `ASSERT_NEXT(a_skid_catch, clk, rst, sample.valid && sample.ready && !adv, skid_full)
  // a held item stays held until the pipe moves
  `ASSERT_NEXT(a_skid_hold, clk, rst, skid_full && !adv, skid_full && $stable(skid_value))

endmodule
